FILE: rtl/nes_pkg.sv
// nes_pkg: types and constants for the variable-store entry scanner.
// No dependencies.
`default_nettype none
package nes_pkg;
  localparam int IMAGE_BYTES = 65536;
  localparam int ADDR_W = $clog2(IMAGE_BYTES);
  localparam int LEN_W = ADDR_W + 1;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_REWIND = 2'd1;
  localparam logic [1:0] OP_FIND = 2'd2;

  localparam logic [15:0] HDR_MIN = 16'h0010;
  localparam logic [15:0] HDR_MAX = 16'h2000;
  localparam logic [7:0] ATTR_ASCII = 8'h02;
  localparam logic [7:0] ATTR_FULL_GUID = 8'h04;
  localparam logic [7:0] ATTR_DATA_ONLY = 8'h08;
  localparam logic [7:0] ATTR_VALID = 8'h80;
  localparam logic [4:0] GUID_BYTES = 5'd16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [15:0] address;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic end_of_image;
    logic [15:0] header_offset;
    logic [15:0] name_offset;
    logic [12:0] name_length;
    logic name_wide;
    logic [16:0] data_offset;
    logic [13:0] data_length;
  } out_item_t;
endpackage
`default_nettype wire

FILE: rtl/nvar_entry_scanner.sv
// nvar_entry_scanner: top level, byte store and scan sequencer.
// Depends on nes_pkg and nes_ram.
`default_nettype none
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | nes_pkg::in_item_t
// out     | output    | out_valid/out_stall| nes_pkg::out_item_t
// cfg     | input     | cfg_we             | image_length (17 bits)
// A find tries one offset after another and reads each byte through the single
// RAM port (address, then data): up to six header bytes and the attribute
// byte per offset, then each name byte, plus a name set-up step and a
// hand-over step for the result.
// No clearing pass after reset. A waiting result holds until taken; the
// next item is taken meanwhile only if it is not a find.
module nvar_entry_scanner (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire nes_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output nes_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [16:0]        cfg_data
);
  import nes_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_NEXT, S_HDR, S_ATTR, S_NAME, S_DONE
  } state_t;

  state_t state_r;
  logic [LEN_W-1:0] len_r, cursor_r, at_r, p_r, end_r, start_r;
  logic [3:0] k_r;
  logic [7:0] b5_lo_r, attr_r, prev_r;
  logic pend_r, odd_r;
  logic [12:0] count_r;
  logic [16:0] cfg_r;
  out_item_t res_r;
  logic res_v_r;

  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0] rdata;
  logic [LEN_W-1:0] rd_addr;
  logic [LEN_W-1:0] live;
  logic in_acc;

  assign live = (cfg_r > 17'(IMAGE_BYTES)) ? LEN_W'(IMAGE_BYTES) : LEN_W'(cfg_r);
  assign in_stall = (state_r != S_IDLE) || (res_v_r && in_data.opcode == OP_FIND);
  assign in_acc = in_valid && !in_stall;
  assign ram_we = in_acc && in_data.opcode == OP_LOAD;
  assign ram_addr = ram_we ? in_data.address[ADDR_W-1:0] : rd_addr[ADDR_W-1:0];
  assign out_valid = res_v_r;
  assign out_data = res_r;

  nes_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_data.byte_value), .rdata(rdata)
  );

  // read address driven from state; pend_r marks an address set last cycle,
  // its data comes back through the registered RAM read
  always_comb begin
    rd_addr = p_r;
  end

  logic [15:0] size_w;
  logic [LEN_W-1:0] end_w, pn_w;
  assign size_w = {rdata, b5_lo_r};
  assign end_w = at_r + LEN_W'(size_w);
  assign pn_w = at_r + LEN_W'(10) + ((attr_r & ATTR_FULL_GUID) != 8'h00 ?
                LEN_W'(GUID_BYTES) : LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cursor_r <= '0;
      cfg_r <= '0;
      res_v_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_data;
      if (res_v_r && !out_stall) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.opcode == OP_REWIND) cursor_r <= '0;
          if (in_acc && in_data.opcode == OP_FIND) begin
            at_r <= cursor_r;
            len_r <= live;
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          out_item_t eoi;
          eoi = '0;
          eoi.end_of_image = 1'b1;
          if (at_r + LEN_W'(16) > len_r || at_r + LEN_W'(16) < at_r) begin
            res_r <= eoi;
            state_r <= S_DONE;
          end else begin
            p_r <= at_r;
            k_r <= '0;
            pend_r <= 1'b1;
            state_r <= S_HDR;
          end
        end
        S_HDR: begin
          // k_r indexes header byte arriving now; next read issued at p_r+1 (at_r+9 after byte 5)
          logic bad;
          bad = 1'b0;
          if (pend_r) begin
            pend_r <= 1'b0;
          end else begin
            unique case (k_r)
              4'd0: bad = rdata != 8'h4E;
              4'd1: bad = rdata != 8'h56;
              4'd2: bad = rdata != 8'h41;
              4'd3: bad = rdata != 8'h52;
              4'd4: b5_lo_r <= rdata;
              4'd5: begin
                bad = size_w < HDR_MIN || size_w > HDR_MAX || end_w > len_r;
                end_r <= end_w;
              end
              default: ;
            endcase
            if (bad) begin
              at_r <= at_r + LEN_W'(1);
              state_r <= S_NEXT;
            end else if (k_r == 4'd5) begin
              p_r <= at_r + LEN_W'(9);
              state_r <= S_ATTR;
              pend_r <= 1'b1;
            end else begin
              k_r <= k_r + 4'd1;
              p_r <= p_r + LEN_W'(1);
              pend_r <= 1'b1;
            end
          end
        end
        S_ATTR: begin
          if (pend_r) begin
            pend_r <= 1'b0;
          end else begin
            attr_r <= rdata;
            if ((rdata & ATTR_VALID) == 8'h00 || (rdata & ATTR_DATA_ONLY) != 8'h00) begin
              at_r <= at_r + LEN_W'(1);
              state_r <= S_NEXT;
            end else begin
              k_r <= 4'd1;
              state_r <= S_NAME;
            end
          end
        end
        S_NAME: begin
          if (k_r == 4'd1) begin
            // set up name start
            if (pn_w >= end_r) begin
              at_r <= at_r + LEN_W'(1);
              state_r <= S_NEXT;
            end else begin
              p_r <= pn_w;
              start_r <= pn_w;
              count_r <= '0;
              odd_r <= 1'b0;
              k_r <= 4'd2;
              pend_r <= 1'b1;
            end
          end else if (pend_r) begin
            pend_r <= 1'b0;
          end else begin
            logic wide, term, stop;
            logic [LEN_W-1:0] pe;
            wide = (attr_r & ATTR_ASCII) == 8'h00;
            term = 1'b0;
            stop = 1'b0;
            pe = p_r;
            if (!wide) begin
              term = rdata == 8'h00;
              pe = p_r + LEN_W'(1);
              stop = term || pe >= end_r;
            end else if (!odd_r) begin
              // low byte; need p+1 < end to continue
              if (p_r + LEN_W'(1) >= end_r) begin
                stop = 1'b1;
                pe = p_r + LEN_W'(2);
              end
            end else begin
              term = prev_r == 8'h00 && rdata == 8'h00;
              pe = p_r + LEN_W'(1);
              stop = term || (pe + LEN_W'(1) >= end_r);
            end
            prev_r <= rdata;
            if (stop) begin
              logic [LEN_W-1:0] pf;
              logic [12:0] cf;
              cf = count_r + ((!term && (!wide || odd_r)) ? 13'd1 : 13'd0);
              pf = term ? (wide ? p_r + LEN_W'(1) : p_r + LEN_W'(1)) :
                   (!wide ? pe + LEN_W'(1) : (odd_r ? pe + LEN_W'(2) : pe));
              if (cf == 13'd0 || pf > end_r) begin
                at_r <= at_r + LEN_W'(1);
                state_r <= S_NEXT;
              end else begin
                res_r.found <= 1'b1;
                res_r.end_of_image <= 1'b0;
                res_r.header_offset <= at_r[15:0];
                res_r.name_offset <= start_r[15:0];
                res_r.name_length <= cf;
                res_r.name_wide <= wide;
                res_r.data_offset <= pf;
                res_r.data_length <= 14'(end_r - pf);
                cursor_r <= at_r + LEN_W'(1);
                state_r <= S_DONE;
              end
            end else begin
              if (!wide || odd_r) count_r <= count_r + 13'd1;
              if (wide) odd_r <= !odd_r;
              p_r <= p_r + LEN_W'(1);
              pend_r <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!res_v_r) begin
            res_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/nes_ram.sv
// nes_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module nes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: dv/nvar_entry_scanner_test.sv
// Self-checking testbench for nvar_entry_scanner: loads variable-store images, runs find
// requests under random stalls and compares each result with a built-in scanner predictor.
// Depends on rtl/nes_pkg.sv and rtl/nvar_entry_scanner.sv.
module nvar_entry_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nes_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [16:0] cfg_data = '0;

  nvar_entry_scanner uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // scanner state as the predictor sees it
  bit [7:0] store_mirror [0:65535];
  int unsigned cursor_mirror;
  int unsigned length_mirror;
  int unsigned loaded_prefix;
  out_item_t found_q[$];
  byte unsigned image_q[$];
  int mismatches = 0;
  int items_sent = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  function automatic bit check_entry(int unsigned at, int unsigned lim, inout out_item_t r);
    int unsigned size, endp, p, start, cnt;
    bit [7:0] attrs;
    bit wide;
    cnt = 0;
    if (store_mirror[at] != "N" || store_mirror[at+1] != "V" ||
        store_mirror[at+2] != "A" || store_mirror[at+3] != "R") return 0;
    size = {store_mirror[at+5], store_mirror[at+4]};
    if (size < HDR_MIN || size > HDR_MAX || at + size > lim) return 0;
    attrs = store_mirror[at+9];
    if ((attrs & ATTR_VALID) == 0 || (attrs & ATTR_DATA_ONLY) != 0) return 0;
    endp = at + size;
    p = at + 10 + (((attrs & ATTR_FULL_GUID) != 0) ? GUID_BYTES : 1);
    if (p >= endp) return 0;
    start = p;
    wide = (attrs & ATTR_ASCII) == 0;
    if (!wide) begin
      while (p < endp && store_mirror[p] != 0) begin
        cnt++;
        p++;
      end
      p += 1;
    end else begin
      while (p + 1 < endp && !(store_mirror[p] == 0 && store_mirror[p+1] == 0)) begin
        cnt++;
        p += 2;
      end
      p += 2;
    end
    if (cnt == 0 || p > endp) return 0;
    r.header_offset = at[15:0];
    r.name_offset = start[15:0];
    r.name_length = cnt[12:0];
    r.name_wide = wide;
    r.data_offset = p[16:0];
    r.data_length = 14'(endp - p);
    return 1;
  endfunction

  function automatic out_item_t scan_next();
    out_item_t r;
    int unsigned lim;
    r = '0;
    lim = (length_mirror > IMAGE_BYTES) ? IMAGE_BYTES : length_mirror;
    for (int unsigned at = cursor_mirror; at + HDR_MIN <= lim; at++) begin
      if (check_entry(at, lim, r)) begin
        r.found = 1'b1;
        cursor_mirror = (at + 1) & 17'h1FFFF;
        return r;
      end
    end
    r = '0;
    r.end_of_image = 1'b1;
    return r;
  endfunction

  task automatic send(logic [1:0] op, logic [15:0] addr, logic [7:0] val);
    in_item_t it;
    it.opcode = op;
    it.address = addr;
    it.byte_value = val;
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (op)
      OP_LOAD: store_mirror[addr] = val;
      OP_REWIND: cursor_mirror = 0;
      OP_FIND: found_q = {found_q, scan_next()};
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_image_length(logic [16:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    length_mirror = v;
  endtask

  function automatic void put_byte(byte unsigned b);
    image_q = {image_q, b};
  endfunction

  // appends one entry to image_q; size_fix skews the size field, term=0 drops the terminator
  function automatic void put_entry(bit [7:0] attrs, int nchars, bit term, int data_n,
                                    int size_fix);
    int base;
    int sz;
    byte unsigned lo, hi;
    base = image_q.size();
    put_byte("N"); put_byte("V");
    put_byte("A"); put_byte("R");
    put_byte(8'h00); put_byte(8'h00);
    repeat (3) put_byte(8'($urandom_range(0, 255)));
    put_byte(attrs);
    repeat (((attrs & ATTR_FULL_GUID) != 0) ? 16 : 1) put_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < nchars; i++) begin
      if ((attrs & ATTR_ASCII) != 0) begin
        put_byte(8'($urandom_range(1, 255)));
      end else begin
        lo = 8'($urandom_range(0, 255));
        hi = 8'($urandom_range(0, 255));
        if (lo == 0 && hi == 0) lo = 8'h41;
        put_byte(lo);
        put_byte(hi);
      end
    end
    if (term) begin
      put_byte(8'h00);
      if ((attrs & ATTR_ASCII) == 0) put_byte(8'h00);
    end
    repeat (data_n) put_byte(8'($urandom_range(1, 255)));
    while (image_q.size() - base < 16) put_byte(8'($urandom_range(1, 255)));
    sz = image_q.size() - base + size_fix;
    if (sz < 0) sz = 0;
    image_q[base+4] = sz[7:0];
    image_q[base+5] = sz[15:8];
  endfunction

  task automatic load_image();
    foreach (image_q[i]) send(OP_LOAD, i[15:0], image_q[i]);
    if (image_q.size() > loaded_prefix) loaded_prefix = image_q.size();
  endtask

  task automatic test_directed_entries();
    image_q.delete();
    put_entry(8'h80 | ATTR_FULL_GUID, 3, 1, 2, 0);
    put_entry(8'h80 | ATTR_ASCII, 4, 1, 1, 0);
    put_entry(8'h80 | ATTR_ASCII | ATTR_DATA_ONLY, 2, 1, 0, 0);
    put_entry(ATTR_ASCII, 2, 1, 0, 0);
    put_entry(8'h80 | ATTR_ASCII, 0, 1, 2, 0);
    put_entry(8'h80 | ATTR_ASCII, 3, 0, 0, 0);
    put_entry(8'h80, 2, 0, 0, 0);
    put_entry(8'h80 | ATTR_ASCII, 2, 1, 0, -8);
    put_entry(8'hFF & ~ATTR_DATA_ONLY, 1, 1, 3, 0);
    load_image();
    send(OP_SPARE, 16'hFFFF, 8'hFF);
    send(OP_LOAD, 16'hFFFF, 8'hA5);
    set_image_length(17'(image_q.size()));
    send(OP_REWIND, '0, '0);
    repeat (5) send(OP_FIND, '0, '0);
    send(OP_REWIND, '0, '0);
    send(OP_FIND, '0, '0);
    set_image_length(17'd0);
    send(OP_FIND, '0, '0);
  endtask

  // biggest entry at the very start, so the scan never walks past written bytes
  task automatic test_extreme_lengths();
    logic [16:0] lens [2];
    lens[0] = 17'h10000;
    lens[1] = 17'h1FFFF;
    image_q.delete();
    put_entry(8'h80 | ATTR_ASCII, 5, 1, 0, 0);
    image_q[4] = 8'h00;
    image_q[5] = 8'h20;
    load_image();
    foreach (lens[k]) begin
      set_image_length(lens[k]);
      send(OP_REWIND, '0, '0);
      send(OP_FIND, '0, '0);
    end
    send(OP_REWIND, '0, '0);
  endtask

  task automatic test_backpressure();
    image_q.delete();
    repeat (6) put_entry(8'h80 | ($urandom_range(0, 1) ? ATTR_ASCII : 8'h00), 2, 1, 1, 0);
    load_image();
    set_image_length(17'(image_q.size()));
    send(OP_REWIND, '0, '0);
    hold_left = 400;
    repeat (8) send(OP_FIND, '0, '0);
    repeat (4) send(OP_LOAD, 16'($urandom_range(image_q.size(), 65535)), 8'($urandom));
    drain();
  endtask

  task automatic test_random_images();
    int target, n, lenv;
    bit [7:0] attrs;
    int phase;
    phase = 0;
    while (items_sent < 1450) begin
      calm = (phase == 3);
      image_q.delete();
      target = $urandom_range(40, 200);
      while (image_q.size() < target) begin
        if ($urandom_range(0, 99) < 80) begin
          attrs = 8'($urandom) & ~ATTR_DATA_ONLY | ATTR_VALID;
          if ($urandom_range(0, 9) == 0) attrs = 8'($urandom);
          put_entry(attrs, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6),
                    $urandom_range(0, 9) != 0, $urandom_range(0, 8),
                    $urandom_range(0, 9) == 0 ? $urandom_range(0, 40) - 20 : 0);
        end else begin
          repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
        end
      end
      load_image();
      case ($urandom_range(0, 5))
        0: lenv = $urandom_range(0, image_q.size());
        1: lenv = loaded_prefix;
        default: lenv = image_q.size();
      endcase
      set_image_length(17'(lenv));
      send(OP_REWIND, '0, '0);
      n = $urandom_range(3, 12);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: send(OP_REWIND, '0, '0);
          1: send(OP_LOAD, 16'($urandom), 8'($urandom));
          2: send(OP_SPARE, 16'($urandom), 8'($urandom));
          3: if (lenv > 0) send(OP_LOAD, 16'($urandom_range(0, lenv - 1)), 8'($urandom));
          default: send(OP_FIND, '0, '0);
        endcase
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 6);
    end
  end

  function automatic void compare_field(string name, longint unsigned e, longint unsigned g);
    if (e != g) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, g);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (found_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        e = found_q.pop_front();
        compare_field("found", e.found, out_data.found);
        compare_field("end_of_image", e.end_of_image, out_data.end_of_image);
        compare_field("header_offset", e.header_offset, out_data.header_offset);
        compare_field("name_offset", e.name_offset, out_data.name_offset);
        compare_field("name_length", e.name_length, out_data.name_length);
        compare_field("name_wide", e.name_wide, out_data.name_wide);
        compare_field("data_offset", e.data_offset, out_data.data_offset);
        compare_field("data_length", e.data_length, out_data.data_length);
      end
    end
  end

  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    cursor_mirror = 0;
    length_mirror = 0;
    loaded_prefix = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_entries();
    test_extreme_lengths();
    test_backpressure();
    test_random_images();
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && found_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

FILE: nvar_entry_scanner.f
rtl/nes_pkg.sv
rtl/nes_ram.sv
rtl/nvar_entry_scanner.sv
dv/nvar_entry_scanner_test.sv
